/* sv/kmv_pkg.sv */
package kmv_pkg;

   localparam int HASH_W       = 64;
   localparam int COUNT_W      = 6;
   localparam int SKETCH_K_DEF = 32;
   localparam int RESULT_LIMIT = 32;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [1:0] ACT_ADD      = 2'd0;
   localparam logic [1:0] ACT_CLEAR    = 2'd1;
   localparam logic [1:0] ACT_READ     = 2'd2;
   localparam logic [1:0] ACT_ESTIMATE = 2'd3;

   localparam logic KIND_ENTRY    = 1'b0;
   localparam logic KIND_ESTIMATE = 1'b1;

   typedef struct packed {
      logic [1:0]        action;
      logic [HASH_W-1:0] hash;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic               entry_valid;
      logic [HASH_W-1:0]  entry_hash;
      logic               last;
      logic [COUNT_W-1:0] held_total;
      logic               count_exact;
      logic [HASH_W-1:0]  estimate_value;
      logic               saturated;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_ADD      = 4'b0001,
      OP_CLEAR    = 4'b0010,
      OP_READ     = 4'b0100,
      OP_ESTIMATE = 4'b1000
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [HASH_W-1:0] hash;
   } item_type;

endpackage

/* sv/kmv_distinct_count_sketch.sv */
// K-minimum-values distinct-count sketch. Push words of {action, hash}: add folds a hash
// into the sorted set of the K smallest distinct hashes, clear empties it, read pops out
// the held hashes in ascending order (at most 32, last one flagged; an empty store gives
// one word with entry_valid low), and estimate returns the exact count below K entries,
// K when the Kth hash is zero, or floor((K-1)*2^64/kth), optionally rounded, saturating
// with a flag. A read streams its result words while the response queue has room, and a
// full-store estimate runs the bit-serial 128-step divider. A four-word queue sits on each
// side, so pushes continue while the back end works or results wait. round_mode is written
// through the csr channel, which is always ready.
module kmv_distinct_count_sketch #(
   parameter int SKETCH_K = kmv_pkg::SKETCH_K_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  kmv_pkg::req_type req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output kmv_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_wdata
);

   logic              round_mode_ff, round_mode_in;
   kmv_pkg::item_type item;
   logic              item_empty, item_pop;
   logic              out_full, out_push;
   kmv_pkg::rsp_type  out_data;
   logic [$bits(kmv_pkg::rsp_type)-1:0] rsp_bits;

   assign csr_ready     = 1'b1;
   assign round_mode_in = (csr_valid && csr_ready) ? csr_wdata : round_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_mode_ff <= 1'b0;
      end else begin
         round_mode_ff <= round_mode_in;
      end
   end

   kmv_front #(
      .DEPTH (kmv_pkg::QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .req_full   (req_full),
      .item_pop   (item_pop),
      .item       (item),
      .item_empty (item_empty)
   );

   kmv_back #(
      .SKETCH_K (SKETCH_K)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .round_mode (round_mode_ff),
      .item       (item),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   kmv_fifo #(
      .WIDTH ($bits(kmv_pkg::rsp_type)),
      .DEPTH (kmv_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_data = kmv_pkg::rsp_type'(rsp_bits);

endmodule

/* sv/kmv_fifo.sv */
module kmv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W:0]   wr_ff, wr_in;
   logic [PTR_W:0]   rd_ff, rd_in;
   logic             do_push, do_pop;

   assign empty   = (wr_ff == rd_ff);
   assign full    = (wr_ff[PTR_W] != rd_ff[PTR_W]) && (wr_ff[PTR_W-1:0] == rd_ff[PTR_W-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff[PTR_W-1:0]];
   assign wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff[PTR_W-1:0]] <= wdata;
      end
   end

endmodule

/* sv/kmv_front.sv */
module kmv_front #(
   parameter int DEPTH = kmv_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  kmv_pkg::req_type   req_data,
   output logic               req_full,
   input  logic               item_pop,
   output kmv_pkg::item_type  item,
   output logic               item_empty
);

   kmv_pkg::item_type cls;
   logic [$bits(kmv_pkg::item_type)-1:0] rd_bits;

   // decode the action into a one-hot op for the back end
   always_comb begin
      cls.hash = req_data.hash;
      case (req_data.action)
         kmv_pkg::ACT_ADD:      cls.op = kmv_pkg::OP_ADD;
         kmv_pkg::ACT_CLEAR:    cls.op = kmv_pkg::OP_CLEAR;
         kmv_pkg::ACT_READ:     cls.op = kmv_pkg::OP_READ;
         default:               cls.op = kmv_pkg::OP_ESTIMATE;
      endcase
   end

   kmv_fifo #(
      .WIDTH ($bits(kmv_pkg::item_type)),
      .DEPTH (DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls),
      .full  (req_full),
      .pop   (item_pop),
      .rdata (rd_bits),
      .empty (item_empty)
   );

   assign item = kmv_pkg::item_type'(rd_bits);

endmodule

/* sv/kmv_back.sv */
module kmv_back #(
   parameter int SKETCH_K = kmv_pkg::SKETCH_K_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              round_mode,
   input  kmv_pkg::item_type item,
   input  logic              item_empty,
   output logic              item_pop,
   input  logic              out_full,
   output logic              out_push,
   output kmv_pkg::rsp_type  out_data
);

   localparam int CNT_W = $clog2(SKETCH_K + 1);
   localparam int IDX_W = $clog2(SKETCH_K);
   localparam int NREAD = (SKETCH_K < kmv_pkg::RESULT_LIMIT) ? SKETCH_K : kmv_pkg::RESULT_LIMIT;
   localparam int HW    = kmv_pkg::HASH_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [HW-1:0]     store_ff [SKETCH_K];
   logic [HW-1:0]     store_in [SKETCH_K];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic [HW-1:0]     div_d_ff, div_d_in;
   logic [HW-1:0]     div_rem_ff, div_rem_in;
   logic [2*HW-1:0]   div_sh_ff, div_sh_in;
   logic [HW-1:0]     div_q_ff, div_q_in;
   logic              div_ovf_ff, div_ovf_in;
   logic [6:0]        div_step_ff, div_step_in;

   logic [SKETCH_K-1:0] lt;
   logic [SKETCH_K-1:0] eq;
   logic                dup, is_full, do_ins;
   logic [HW-1:0]       kth;
   logic [CNT_W-1:0]    lim;
   logic                rd_last;
   logic [HW:0]         r65, sub65;
   logic                ge;
   logic [HW:0]         twice_rem;
   logic                rnd;

   assign is_full = (count_ff == CNT_W'(SKETCH_K));
   assign kth     = store_ff[SKETCH_K-1];
   assign lim     = (count_ff > CNT_W'(NREAD)) ? CNT_W'(NREAD) : count_ff;
   assign rd_last = ((CNT_W'(idx_ff) + 1'b1) == lim);

   // parallel compare against every held entry; slots past the count act as open
   always_comb begin
      for (int i = 0; i < SKETCH_K; i++) begin
         lt[i] = (CNT_W'(i) >= count_ff) || (item.hash < store_ff[i]);
         eq[i] = (CNT_W'(i) < count_ff) && (item.hash == store_ff[i]);
      end
   end
   assign dup    = |eq;
   assign do_ins = !dup && !(is_full && !lt[SKETCH_K-1]);

   always_comb begin
      for (int i = 0; i < SKETCH_K; i++) begin
         if (!lt[i]) begin
            store_in[i] = store_ff[i];
         end else if (i == 0) begin
            store_in[i] = item.hash;
         end else if (!lt[(i > 0) ? i - 1 : 0]) begin
            store_in[i] = item.hash;
         end else begin
            store_in[i] = store_ff[(i > 0) ? i - 1 : 0];
         end
      end
   end

   // one restoring division step per cycle
   assign r65   = {div_rem_ff, div_sh_ff[2*HW-1]};
   assign sub65 = r65 - {1'b0, div_d_ff};
   assign ge    = (r65 >= {1'b0, div_d_ff});

   assign twice_rem = {div_rem_ff, 1'b0};
   assign rnd       = round_mode && !div_ovf_ff && (twice_rem >= {1'b0, div_d_ff});

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      div_d_in    = div_d_ff;
      div_rem_in  = div_rem_ff;
      div_sh_in   = div_sh_ff;
      div_q_in    = div_q_ff;
      div_ovf_in  = div_ovf_ff;
      div_step_in = div_step_ff;
      item_pop    = 1'b0;
      out_push    = 1'b0;

      out_data.kind           = kmv_pkg::KIND_ENTRY;
      out_data.entry_valid    = 1'b0;
      out_data.entry_hash     = '0;
      out_data.last           = 1'b0;
      out_data.held_total     = kmv_pkg::COUNT_W'(count_ff);
      out_data.count_exact    = !is_full;
      out_data.estimate_value = '0;
      out_data.saturated      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!item_empty) begin
               case (item.op)
                  kmv_pkg::OP_ADD: begin
                     item_pop = 1'b1;
                     if (do_ins && !is_full) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  kmv_pkg::OP_CLEAR: begin
                     item_pop = 1'b1;
                     count_in = '0;
                  end
                  kmv_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        out_data.last = 1'b1;
                        if (!out_full) begin
                           out_push = 1'b1;
                           item_pop = 1'b1;
                        end
                     end else begin
                        item_pop = 1'b1;
                        idx_in   = '0;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     out_data.kind = kmv_pkg::KIND_ESTIMATE;
                     if (!is_full) begin
                        out_data.estimate_value = HW'(count_ff);
                        if (!out_full) begin
                           out_push = 1'b1;
                           item_pop = 1'b1;
                        end
                     end else if (kth == '0) begin
                        out_data.estimate_value = HW'(SKETCH_K);
                        if (!out_full) begin
                           out_push = 1'b1;
                           item_pop = 1'b1;
                        end
                     end else begin
                        item_pop    = 1'b1;
                        div_d_in    = kth;
                        div_rem_in  = '0;
                        div_sh_in   = {HW'(SKETCH_K - 1), {HW{1'b0}}};
                        div_q_in    = '0;
                        div_ovf_in  = 1'b0;
                        div_step_in = 7'd127;
                        state_in    = ST_DIV;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            out_data.entry_valid = 1'b1;
            out_data.entry_hash  = store_ff[idx_ff];
            out_data.last        = rd_last;
            if (!out_full) begin
               out_push = 1'b1;
               idx_in   = idx_ff + 1'b1;
               if (rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            div_rem_in = ge ? sub65[HW-1:0] : r65[HW-1:0];
            div_sh_in  = {div_sh_ff[2*HW-2:0], 1'b0};
            if (div_step_ff[6]) begin
               div_ovf_in = div_ovf_ff || ge;
            end else begin
               div_q_in = {div_q_ff[HW-2:0], ge};
            end
            div_step_in = div_step_ff - 1'b1;
            if (div_step_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            out_data.kind = kmv_pkg::KIND_ESTIMATE;
            if (div_ovf_ff || (rnd && (div_q_ff == '1))) begin
               out_data.estimate_value = '1;
               out_data.saturated      = 1'b1;
            end else if (rnd) begin
               out_data.estimate_value = div_q_ff + 1'b1;
            end else begin
               out_data.estimate_value = div_q_ff;
            end
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      div_d_ff    <= div_d_in;
      div_rem_ff  <= div_rem_in;
      div_sh_ff   <= div_sh_in;
      div_q_ff    <= div_q_in;
      div_ovf_ff  <= div_ovf_in;
      div_step_ff <= div_step_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && !item_empty && item.op == kmv_pkg::OP_ADD && do_ins) begin
         for (int i = 0; i < SKETCH_K; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

endmodule
